[rtl/run_length_gap_penalty_defines.svh]
// assertion macros shared by the run-length gap penalty rtl
`ifndef RUN_LENGTH_GAP_PENALTY_DEFINES_SVH
`define RUN_LENGTH_GAP_PENALTY_DEFINES_SVH
`ifndef SYNTHESIS
`define RLGP_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define RLGP_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define RLGP_ASSERT_IMPL(lbl, ck, rst_n, ante, cons)
`define RLGP_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

[rtl/rlgp_pkg.sv]
// shared types, constants and exponent table of the run-length gap penalty block
package rlgp_pkg;
	localparam int FRAC_BITS = 8;
	localparam int Q_BITS = 30;
	localparam int TAB_SIZE = 2 ** FRAC_BITS;
	localparam int EXP_STEPS = 31;
	localparam int K_W = 5;
	localparam int DIV_STEPS = Q_BITS;
	localparam int U_W = Q_BITS + 1;
	localparam int OUT_W = 24;
	localparam int N_W = 16;
	localparam int PAR_W = 20;
	localparam int SCORE_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DIFF_W = N_W + FRAC_BITS + 2;
	localparam int PROD_W = PAR_W + DIFF_W;
	localparam int T_W = PROD_W - FRAC_BITS;
	localparam int KF_W = T_W - FRAC_BITS;
	localparam logic [U_W-1:0] Q_ONE = U_W'(64'd1 << Q_BITS);

	localparam logic [1:0] MODE_CONST = 2'd0;
	localparam logic [1:0] MODE_PIECE = 2'd1;
	localparam logic [1:0] MODE_EXP = 2'd2;
	localparam logic [1:0] MODE_LOGISTIC = 2'd3;

	typedef logic [U_W-1:0] exp_tab_t [TAB_SIZE];

	typedef struct packed {
		logic signed [SCORE_W-1:0] base_penalty;
		logic signed [SCORE_W-1:0] floor_score;
		logic [1:0] shape_mode;
		logic signed [PAR_W-1:0] param_one;
		logic signed [PAR_W-1:0] param_two;
		logic signed [PAR_W-1:0] param_three;
		logic signed [PAR_W-1:0] param_four;
	} rlgp_cfg_t;

	typedef struct packed {
		logic blend;
		logic mode3;
		logic neg;
		logic signed [OUT_W-1:0] direct;
	} rlgp_side_t;

	// truncated taylor series of e^-y, y in q30
	function automatic logic [63:0] exp_series(input logic [63:0] y);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		term = 64'd1 << Q_BITS;
		pos = term;
		neg = '0;
		for (int i = 1; i <= 20; i++) begin
			term = ((term * y) >> Q_BITS) / 64'(i);
			if (i[0]) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		for (int f = 0; f < TAB_SIZE; f++) begin
			tab[f] = U_W'(exp_series(64'(f) << (Q_BITS - FRAC_BITS)));
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();
	localparam logic [U_W-1:0] EXP_ONE_STEP = U_W'(exp_series(64'd1 << Q_BITS));
endpackage

[rtl/rlgp_front.sv]
// front stages: piecewise score, logistic exponent product and exponent split
module rlgp_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [rlgp_pkg::N_W-1:0] run_length,
	input rlgp_pkg::rlgp_cfg_t cfg,
	output logic valid_o,
	output logic [rlgp_pkg::K_W-1:0] k_o,
	output logic [rlgp_pkg::FRAC_BITS-1:0] f_o,
	output logic zero_o,
	output rlgp_pkg::rlgp_side_t side_o
);
	import rlgp_pkg::*;

	logic signed [DIFF_W-1:0] nf;
	logic signed [DIFF_W-1:0] g1_x;
	logic signed [DIFF_W-1:0] g3_x;
	logic signed [SCORE_W:0] pm_sum;
	logic signed [OUT_W-1:0] pfix;
	logic signed [OUT_W-1:0] mid;
	logic signed [OUT_W-1:0] piece;
	logic in_one;
	logic in_two;
	logic nz;
	rlgp_side_t side_d;

	logic valid_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic [N_W-1:0] nm1_s1;
	rlgp_side_t side_s1;

	logic valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [N_W-1:0] nm1_s2;
	rlgp_side_t side_s2;

	logic signed [PROD_W-1:0] prod_d;
	logic signed [T_W-1:0] t_d;
	logic [T_W-1:0] mag_d;
	logic [KF_W-1:0] kf_d;
	logic [FRAC_BITS-1:0] f_d;
	rlgp_side_t side_d3;

	logic valid_s3;
	logic [K_W-1:0] k_s3;
	logic [FRAC_BITS-1:0] f_s3;
	logic zero_s3;
	rlgp_side_t side_s3;

	always_comb begin
		nf = {1'b0, 1'b0, run_length, {FRAC_BITS{1'b0}}};
		g1_x = DIFF_W'(cfg.param_one);
		g3_x = DIFF_W'(cfg.param_three);
		pm_sum = (SCORE_W + 1)'(cfg.base_penalty) + (SCORE_W + 1)'(cfg.floor_score);
		pfix = OUT_W'({cfg.base_penalty, {FRAC_BITS{1'b0}}});
		mid = OUT_W'({pm_sum, {(FRAC_BITS - 1){1'b0}}});
		in_one = (nf >= g1_x) && ((nf < g3_x) || (cfg.param_three <= 20'sd0));
		in_two = (cfg.param_three > 20'sd0) && (nf >= g3_x);
		priority if (in_one) begin
			piece = (cfg.param_two < 20'sd0) ? OUT_W'(cfg.param_two) : mid;
		end else if (in_two) begin
			piece = (cfg.param_four < 20'sd0) ? OUT_W'(cfg.param_four) : mid;
		end else begin
			piece = pfix;
		end
		nz = (run_length != '0);
		side_d.direct = (nz && cfg.shape_mode == MODE_PIECE) ? piece : pfix;
		side_d.blend = nz && (cfg.shape_mode == MODE_EXP || cfg.shape_mode == MODE_LOGISTIC);
		side_d.mode3 = nz && (cfg.shape_mode == MODE_LOGISTIC);
		side_d.neg = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= nf - DIFF_W'(cfg.param_two);
			nm1_s1 <= N_W'(run_length - N_W'(1));
			side_s1 <= side_d;
		end
	end

	assign prod_d = cfg.param_one * diff_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod_d;
			nm1_s2 <= nm1_s1;
			side_s2 <= side_s1;
		end
	end

	always_comb begin
		t_d = T_W'(prod_s2 >>> FRAC_BITS);
		mag_d = t_d[T_W-1] ? T_W'(-t_d) : T_W'(t_d);
		side_d3 = side_s2;
		side_d3.neg = side_s2.mode3 && t_d[T_W-1];
		if (side_s2.mode3) begin
			kf_d = mag_d[T_W-1:FRAC_BITS];
			f_d = mag_d[FRAC_BITS-1:0];
		end else begin
			kf_d = KF_W'(nm1_s2);
			f_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s3 <= kf_d[K_W-1:0];
			f_s3 <= f_d;
			zero_s3 <= (kf_d > KF_W'(EXP_STEPS));
			side_s3 <= side_d3;
		end
	end

	assign valid_o = valid_s3;
	assign k_o = k_s3;
	assign f_o = f_s3;
	assign zero_o = zero_s3;
	assign side_o = side_s3;
endmodule

[rtl/rlgp_exp.sv]
// exponential pipeline: fraction table then one truncating e^-1 step per stage
`include "run_length_gap_penalty_defines.svh"
module rlgp_exp (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid_i,
	input logic [rlgp_pkg::K_W-1:0] k_i,
	input logic [rlgp_pkg::FRAC_BITS-1:0] f_i,
	input logic zero_i,
	input rlgp_pkg::rlgp_side_t side_i,
	output logic valid_o,
	output logic [rlgp_pkg::U_W-1:0] u_o,
	output rlgp_pkg::rlgp_side_t side_o
);
	import rlgp_pkg::*;

	logic [EXP_STEPS:0] valid_s;
	logic [EXP_STEPS:0] zero_s;
	logic [U_W-1:0] r_s [EXP_STEPS+1];
	logic [K_W-1:0] k_s [EXP_STEPS+1];
	rlgp_side_t side_s [EXP_STEPS+1];
	logic [2*U_W-1:0] prod [EXP_STEPS];
	logic [U_W-1:0] r_next [EXP_STEPS];

	always_comb begin
		for (int j = 0; j < EXP_STEPS; j++) begin
			prod[j] = r_s[j] * EXP_ONE_STEP;
			r_next[j] = (k_s[j] > K_W'(j)) ? prod[j][Q_BITS +: U_W] : r_s[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[EXP_STEPS-1:0], valid_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= EXP_TAB[f_i];
			k_s[0] <= k_i;
			zero_s[0] <= zero_i;
			side_s[0] <= side_i;
			for (int j = 1; j <= EXP_STEPS; j++) begin
				r_s[j] <= r_next[j-1];
				k_s[j] <= k_s[j-1];
				zero_s[j] <= zero_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign valid_o = valid_s[EXP_STEPS];
	assign u_o = zero_s[EXP_STEPS] ? '0 : r_s[EXP_STEPS];
	assign side_o = side_s[EXP_STEPS];

	`RLGP_ASSERT_IMPL(a_exp_le_one, clk, arst_n, valid_o, u_o <= Q_ONE)
endmodule

[rtl/rlgp_div.sv]
// restoring divider pipeline: u * 2^30 / (2^30 + u), one quotient bit per stage
`include "run_length_gap_penalty_defines.svh"
module rlgp_div (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid_i,
	input logic [rlgp_pkg::U_W-1:0] u_i,
	input rlgp_pkg::rlgp_side_t side_i,
	output logic valid_o,
	output logic [rlgp_pkg::Q_BITS-1:0] q_o,
	output logic [rlgp_pkg::U_W-1:0] u_o,
	output rlgp_pkg::rlgp_side_t side_o
);
	import rlgp_pkg::*;

	localparam int DIV_W = U_W + 1;

	logic [DIV_STEPS:0] valid_s;
	logic [DIV_W-1:0] rem_s [DIV_STEPS+1];
	logic [DIV_W-1:0] dvs_s [DIV_STEPS+1];
	logic [Q_BITS-1:0] q_s [DIV_STEPS+1];
	logic [U_W-1:0] u_s [DIV_STEPS+1];
	rlgp_side_t side_s [DIV_STEPS+1];
	logic [DIV_W-1:0] shl [DIV_STEPS];
	logic [DIV_STEPS-1:0] ge;

	always_comb begin
		for (int j = 0; j < DIV_STEPS; j++) begin
			shl[j] = {rem_s[j][DIV_W-2:0], 1'b0};
			ge[j] = (shl[j] >= dvs_s[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[DIV_STEPS-1:0], valid_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DIV_W'(u_i);
			dvs_s[0] <= DIV_W'(u_i) + DIV_W'(Q_ONE);
			q_s[0] <= '0;
			u_s[0] <= u_i;
			side_s[0] <= side_i;
			for (int j = 1; j <= DIV_STEPS; j++) begin
				rem_s[j] <= ge[j-1] ? shl[j-1] - dvs_s[j-1] : shl[j-1];
				dvs_s[j] <= dvs_s[j-1];
				q_s[j] <= {q_s[j-1][Q_BITS-2:0], ge[j-1]};
				u_s[j] <= u_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign valid_o = valid_s[DIV_STEPS];
	assign q_o = q_s[DIV_STEPS];
	assign u_o = u_s[DIV_STEPS];
	assign side_o = side_s[DIV_STEPS];

	`RLGP_ASSERT_IMPL(a_quot_le_half, clk, arst_n, valid_o, q_o <= (Q_ONE >> 1))
endmodule

[rtl/run_length_gap_penalty.sv]
// run-length gap penalty: fully pipelined, one item per cycle while the skid is empty
// (3 front stages, 32 exponent stages, 31 divider stages, 2 blend stages, output register)
// a one-entry skid behind the output register holds a result while the output waits, and
// s_axis_tready is low while the skid is full
// reset clears all valid bits and loads the register defaults; no clearing pass
`include "run_length_gap_penalty_defines.svh"
module run_length_gap_penalty (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rlgp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rlgp_pkg::PAR_W-1:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [rlgp_pkg::N_W-1:0] s_axis_tdata, // [15:0] run_length
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [rlgp_pkg::OUT_W-1:0] m_axis_tdata // [23:0] penalty_score
);
	import rlgp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TWO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THREE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FOUR = 3'd6;

	localparam int SH = Q_BITS - FRAC_BITS;
	localparam int V_W = SCORE_W + 1 + U_W + 1;
	localparam int RES_W = V_W - SH + 1;
	localparam logic signed [V_W-1:0] ROUND_HALF = V_W'(64'd1 << (SH - 1));
	localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-(64'sd1 <<< (OUT_W - 1)));

	rlgp_cfg_t cfg_q;
	logic en;

	logic f_valid;
	logic [K_W-1:0] f_k;
	logic [FRAC_BITS-1:0] f_f;
	logic f_zero;
	rlgp_side_t f_side;

	logic e_valid;
	logic [U_W-1:0] e_u;
	rlgp_side_t e_side;

	logic d_valid;
	logic [Q_BITS-1:0] d_q;
	logic [U_W-1:0] d_u;
	rlgp_side_t d_side;

	logic [U_W-1:0] scale_d;
	logic valid_s1;
	logic [U_W-1:0] scale_s1;
	rlgp_side_t side_s1;
	logic signed [SCORE_W:0] pm_diff;
	logic signed [V_W-1:0] prod_d;
	logic valid_s2;
	logic signed [V_W-1:0] prod_s2;
	rlgp_side_t side_s2;

	logic signed [RES_W-1:0] rnd;
	logic signed [RES_W-1:0] res;
	logic signed [OUT_W-1:0] sat;
	logic [OUT_W-1:0] tail_data;

	logic out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic skid_valid_q;
	logic [OUT_W-1:0] skid_data_q;
	logic take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_penalty <= -16'sd175;
			cfg_q.floor_score <= -16'sd125;
			cfg_q.shape_mode <= MODE_CONST;
			cfg_q.param_one <= '0;
			cfg_q.param_two <= '0;
			cfg_q.param_three <= '0;
			cfg_q.param_four <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE: cfg_q.base_penalty <= cfg_data[SCORE_W-1:0];
				REG_FLOOR: cfg_q.floor_score <= cfg_data[SCORE_W-1:0];
				REG_MODE: cfg_q.shape_mode <= cfg_data[1:0];
				REG_ONE: cfg_q.param_one <= cfg_data;
				REG_TWO: cfg_q.param_two <= cfg_data;
				REG_THREE: cfg_q.param_three <= cfg_data;
				REG_FOUR: cfg_q.param_four <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign en = !skid_valid_q;
	assign s_axis_tready = en;

	rlgp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_axis_tvalid),
		.run_length(s_axis_tdata),
		.cfg(cfg_q),
		.valid_o(f_valid),
		.k_o(f_k),
		.f_o(f_f),
		.zero_o(f_zero),
		.side_o(f_side)
	);

	rlgp_exp u_exp (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_i(f_valid),
		.k_i(f_k),
		.f_i(f_f),
		.zero_i(f_zero),
		.side_i(f_side),
		.valid_o(e_valid),
		.u_o(e_u),
		.side_o(e_side)
	);

	rlgp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_i(e_valid),
		.u_i(e_u),
		.side_i(e_side),
		.valid_o(d_valid),
		.q_o(d_q),
		.u_o(d_u),
		.side_o(d_side)
	);

	always_comb begin
		if (d_side.mode3) begin
			scale_d = d_side.neg ? Q_ONE - U_W'(d_q) : U_W'(d_q);
		end else begin
			scale_d = d_u;
		end
	end

	assign pm_diff = (SCORE_W + 1)'(cfg_q.base_penalty) - (SCORE_W + 1)'(cfg_q.floor_score);
	assign prod_d = pm_diff * $signed({1'b0, scale_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= d_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scale_s1 <= scale_d;
			side_s1 <= d_side;
			prod_s2 <= prod_d;
			side_s2 <= side_s1;
		end
	end

	always_comb begin
		rnd = RES_W'((prod_s2 + ROUND_HALF) >>> SH);
		res = rnd + RES_W'($signed({cfg_q.floor_score, {FRAC_BITS{1'b0}}}));
		priority if (res > SAT_HI) begin
			sat = OUT_W'(SAT_HI);
		end else if (res < SAT_LO) begin
			sat = OUT_W'(SAT_LO);
		end else begin
			sat = OUT_W'(res);
		end
		tail_data = side_s2.blend ? sat : side_s2.direct;
	end

	assign take = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (valid_s2) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_valid_q || take) begin
				out_data_q <= skid_data_q;
			end
		end else if (valid_s2) begin
			if (out_valid_q && !take) begin
				skid_data_q <= tail_data;
			end else begin
				out_data_q <= tail_data;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	`RLGP_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`RLGP_ASSERT_NEXT(a_skid_holds, clk, arst_n, skid_valid_q && !m_axis_tready, skid_valid_q)
endmodule

[tb/tb.sv]
// self-checking testbench for run_length_gap_penalty: random and directed run lengths
`timescale 1ns / 1ps
module tb;
	import rlgp_pkg::*;

	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam int SETTLE_CYCLES = 100;

	typedef enum logic [2:0] {
		REG_BASE = 3'd0,
		REG_FLOOR = 3'd1,
		REG_MODE = 3'd2,
		REG_PONE = 3'd3,
		REG_PTWO = 3'd4,
		REG_PTHREE = 3'd5,
		REG_PFOUR = 3'd6
	} reg_idx_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PAR_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [N_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	longint cur_base = -175;
	longint cur_floor = -125;
	int unsigned cur_mode = 0;
	longint cur_pone = 0;
	longint cur_ptwo = 0;
	longint cur_pthree = 0;
	longint cur_pfour = 0;

	logic [N_W-1:0] pending_runs[$];
	logic [OUT_W-1:0] expected_scores[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit hold_arm = 1'b0;
	int unsigned hold_cnt = 0;
	int unsigned mismatches = 0;
	int unsigned failures = 0;

	run_length_gap_penalty dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint sign_ext(longint unsigned v, int w);
		longint unsigned m;
		m = (64'd1 << w) - 1;
		v = v & m;
		if (v[w-1])
			return longint'(v) - longint'(64'd1 << w);
		return longint'(v);
	endfunction

	function automatic longint unsigned taylor_exp(longint unsigned y);
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		term = Q30;
		pos = Q30;
		neg = 0;
		for (int i = 1; i <= 20; i++) begin
			term = ((term * y) >> 30) / longint'(i);
			if (i % 2 == 1)
				neg += term;
			else
				pos += term;
		end
		return pos > neg ? pos - neg : 64'd0;
	endfunction

	function automatic longint unsigned decay_q30(longint x);
		longint unsigned k;
		longint unsigned f;
		longint unsigned r;
		longint unsigned e1;
		k = longint'(x) >>> FRAC_BITS;
		f = x & ((64'd1 << FRAC_BITS) - 1);
		if (k >= 32)
			return 0;
		r = taylor_exp(f << (30 - FRAC_BITS));
		e1 = taylor_exp(Q30);
		while (k > 0) begin
			r = (r * e1) >> 30;
			k--;
		end
		return r;
	endfunction

	function automatic longint mix_toward_floor(longint unsigned s);
		longint v;
		v = (cur_base - cur_floor) * longint'(s);
		return ((v + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS))
			+ cur_floor * (64'sd1 << FRAC_BITS);
	endfunction

	function automatic logic [OUT_W-1:0] gap_score(logic [N_W-1:0] n);
		longint nf;
		longint mid;
		longint r;
		longint t;
		longint unsigned u;
		longint unsigned q;
		nf = longint'(n) <<< FRAC_BITS;
		mid = (cur_base + cur_floor) * (64'sd1 << (FRAC_BITS - 1));
		r = cur_base * (64'sd1 << FRAC_BITS);
		if (n != 0) begin
			if (cur_mode == MODE_PIECE) begin
				if (nf >= cur_pone && (nf < cur_pthree || cur_pthree <= 0))
					r = cur_ptwo < 0 ? cur_ptwo : mid;
				else if (cur_pthree > 0 && nf >= cur_pthree)
					r = cur_pfour < 0 ? cur_pfour : mid;
			end else if (cur_mode == MODE_EXP) begin
				r = mix_toward_floor(decay_q30((longint'(n) - 1) <<< FRAC_BITS));
			end else if (cur_mode == MODE_LOGISTIC) begin
				t = (cur_pone * (nf - cur_ptwo)) >>> FRAC_BITS;
				if (t >= 0) begin
					u = decay_q30(t);
					q = (u << 30) / (Q30 + u);
				end else begin
					u = decay_q30(-t);
					q = Q30 - (u << 30) / (Q30 + u);
				end
				r = mix_toward_floor(q);
			end
		end
		if (r > 64'sd8388607)
			r = 64'sd8388607;
		if (r < -64'sd8388608)
			r = -64'sd8388608;
		return r[OUT_W-1:0];
	endfunction

	// input side
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			expected_scores.push_back(gap_score(s_axis_tdata));
		if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && pending_runs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_runs.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// long output hold-off
	always @(posedge clk) begin
		if (hold_cnt > 0)
			hold_cnt <= hold_cnt - 1;
		else if (hold_arm)
			hold_cnt <= 400;
	end

	// output side
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_scores.size() == 0) begin
				failures++;
				if (mismatches < 10)
					$display("unexpected result %0d", $signed(m_axis_tdata));
				mismatches++;
			end else begin
				want = expected_scores.pop_front();
				if (want !== m_axis_tdata) begin
					failures++;
					if (mismatches < 10)
						$display("penalty_score mismatch: expected %0d got %0d",
							$signed(want), $signed(m_axis_tdata));
					mismatches++;
				end
			end
		end
		m_axis_tready <= arst_n && hold_cnt == 0 && !hold_arm
			&& $urandom_range(99) >= recv_stall_pct;
	end

	task automatic write_reg(reg_idx_e idx, logic [PAR_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BASE: cur_base = sign_ext(val, SCORE_W);
			REG_FLOOR: cur_floor = sign_ext(val, SCORE_W);
			REG_MODE: cur_mode = 32'(val[1:0]);
			REG_PONE: cur_pone = sign_ext(val, PAR_W);
			REG_PTWO: cur_ptwo = sign_ext(val, PAR_W);
			REG_PTHREE: cur_pthree = sign_ext(val, PAR_W);
			REG_PFOUR: cur_pfour = sign_ext(val, PAR_W);
			default: ;
		endcase
	endtask

	function automatic logic [PAR_W-1:0] pick_param(int unsigned mode);
		case ($urandom_range(9))
			0: return 20'h80000;
			1: return 20'h7ffff;
			2: return '0;
			3: return PAR_W'($urandom());
			default: begin
				if (mode == MODE_LOGISTIC)
					return PAR_W'($urandom_range(1024) - 512);
				return PAR_W'(($urandom_range(40) - 8) * 256 + $urandom_range(255));
			end
		endcase
	endfunction

	function automatic logic [PAR_W-1:0] pick_score();
		case ($urandom_range(7))
			0: return 20'h08000;
			1: return '0;
			2: return PAR_W'($urandom());
			default: return PAR_W'(-$urandom_range(400));
		endcase
	endfunction

	function automatic logic [N_W-1:0] pick_run();
		case ($urandom_range(9))
			0: return N_W'($urandom());
			1: return 16'hffff;
			default: return N_W'($urandom_range(48));
		endcase
	endfunction

	initial begin
		int unsigned mode;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// reset defaults first
		pending_runs = '{16'd0, 16'd1, 16'd2, 16'hffff, 16'h8000};
		wait (pending_runs.size() == 0 && expected_scores.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int ph = 0; ph < 16; ph++) begin
			mode = ph % 4;
			case ((ph / 4) % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 73; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 73; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			if (ph == 0) begin
				write_reg(REG_BASE, 20'h08000);
				write_reg(REG_FLOOR, '0);
			end else if (ph == 1) begin
				write_reg(REG_BASE, '0);
				write_reg(REG_FLOOR, 20'h08000);
			end else begin
				write_reg(REG_BASE, pick_score());
				write_reg(REG_FLOOR, pick_score());
			end
			write_reg(REG_MODE, PAR_W'(mode) | PAR_W'($urandom() & 32'hffffc));
			write_reg(REG_PONE, pick_param(mode));
			write_reg(REG_PTWO, pick_param(mode));
			write_reg(REG_PTHREE, pick_param(mode));
			write_reg(REG_PFOUR, pick_param(mode));
			pending_runs.push_back(16'd0);
			pending_runs.push_back(16'd1);
			pending_runs.push_back(16'hffff);
			for (int i = 0; i < 40; i++)
				pending_runs.push_back(pick_run());
			if (ph == 8) begin
				// enough items to fill the pipeline during the hold-off
				for (int i = 0; i < 120; i++)
					pending_runs.push_back(pick_run());
				hold_arm = 1'b1;
				wait (hold_cnt != 0);
				hold_arm = 1'b0;
			end
			wait (pending_runs.size() == 0 && expected_scores.size() == 0);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
		if (failures == 0)
			$display("run_length_gap_penalty test passed");
		else
			$display("run_length_gap_penalty test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("run_length_gap_penalty test failed");
		$finish;
	end
endmodule

[run_length_gap_penalty.f]
+incdir+rtl
rtl/rlgp_pkg.sv
rtl/rlgp_front.sv
rtl/rlgp_exp.sv
rtl/rlgp_div.sv
rtl/run_length_gap_penalty.sv
tb/tb.sv
